### sv/assert_macros.svh
// Assertion macros shared by the parser RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that a condition holds at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error(msg);

// Checks that a trigger is followed by a condition on the next clock edge.
`define ASSERT_NEXT(lbl, trig, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (trig) |=> (cond)) \
      else $error(msg);

`endif

### sv/pfp_pkg.sv
// Types and constants of the property frame parser.
package pfp_pkg;

   localparam int unsigned RSP_DEPTH = 4;
   localparam int unsigned TDATA_W = 104;

   localparam logic [3:0] HDR_LAST_IDX = 4'd11;
   localparam logic [3:0] HDR_ID_LAST = 4'd3;
   localparam logic [3:0] HDR_SRC_LAST = 4'd6;
   localparam logic [3:0] HDR_DST_LAST = 4'd9;
   localparam logic [3:0] HDR_SVC_IDX = 4'd10;

   localparam logic [7:0] HEADER_ONE_RST = 8'd16;
   localparam logic [7:0] HEADER_TWO_RST = 8'd129;
   localparam logic [7:0] RW_REQ_RST = 8'd110;
   localparam logic [7:0] RW_RSP_RST = 8'd126;
   localparam logic [7:0] RW_ERR_RST = 8'd94;

   typedef enum logic [2:0] {
      REG_HEADER_ONE = 3'd0,
      REG_HEADER_TWO = 3'd1,
      REG_RW_REQ = 3'd2,
      REG_RW_RSP = 3'd3,
      REG_RW_ERR = 3'd4
   } reg_idx_type;

   typedef enum logic [2:0] {
      KIND_HEADER = 3'd0,
      KIND_PROP = 3'd1,
      KIND_DATA = 3'd2,
      KIND_DONE = 3'd3,
      KIND_ERROR = 3'd4
   } kind_type;

   typedef enum logic [1:0] {
      LIST_SINGLE = 2'd0,
      LIST_SET = 2'd1,
      LIST_GET = 2'd2
   } list_type;

   typedef enum logic [1:0] {
      CAUSE_NONE = 2'd0,
      CAUSE_SHORT = 2'd1,
      CAUSE_HDR_ONE = 2'd2,
      CAUSE_HDR_TWO = 2'd3
   } cause_type;

   typedef enum logic [6:0] {
      PH_HEADER = 7'b0000001,
      PH_CODE = 7'b0000010,
      PH_LEN = 7'b0000100,
      PH_DATA = 7'b0001000,
      PH_GETCOUNT = 7'b0010000,
      PH_TRAIL = 7'b0100000,
      PH_SKIP = 7'b1000000
   } phase_type;

   typedef struct packed {
      kind_type kind;
      logic [15:0] trans_id;
      logic [23:0] src_object;
      logic [23:0] dst_object;
      logic [7:0] service_code;
      logic [1:0] list_id;
      logic [7:0] property_code;
      logic [7:0] data_count;
      logic [7:0] payload_byte;
      logic [1:0] error_cause;
      logic last_of_item;
   } rec_type;

endpackage

### sv/property_frame_parser.sv
// Top level of the property frame parser: byte parser and result queue.
//
// Usage: datagram bytes enter on the req_ stream, one byte per beat, with
// req_tlast set on the final byte of each datagram. Results leave on the
// rsp_ stream: rsp_tuser gives the record kind (header, property start,
// data byte, frame done, frame error) and rsp_tdata the record fields.
// rsp_tlast marks the last result caused by one input byte. Expected header
// bytes and the three two-list service codes are set through the csr_ port.
//
// Each result is written into the result queue and offered on rsp_ from
// its head. Throughput: one byte per cycle while req_tready is high. A
// byte yields at most two results (a frame-ending byte that also carries
// a record yields two); the result queue (RspDepth entries) drains one
// entry a cycle. req_tready is high while the queue has room for two
// results, so a receiver that stalls fills the queue and then holds off
// the sender; no result is lost or repeated.
//
// Reset clears the queue, returns the parser to waiting for a header and
// loads the register defaults. Every frame end also returns the parser to
// its start state.
`include "assert_macros.svh"

module property_frame_parser #(
   parameter int unsigned RspDepth = pfp_pkg::RSP_DEPTH
) (
   input logic clock,
   input logic reset,
   // Input stream.
   input logic req_tvalid,
   output logic req_tready,
   input logic [7:0] req_tdata, // in_byte
   input logic req_tlast, // frame_end
   // Result stream.
   output logic rsp_tvalid,
   input logic rsp_tready,
   // From bit 0: trans_id[15:0], src_object[39:16], dst_object[63:40],
   // service_code[71:64], list_id[73:72], property_code[81:74],
   // data_count[89:82], payload_byte[97:90], error_cause[99:98], zeros.
   output logic [pfp_pkg::TDATA_W-1:0] rsp_tdata,
   output logic [2:0] rsp_tuser, // kind
   output logic rsp_tlast, // last_of_item
   // Register writes.
   input logic csr_we,
   input logic [2:0] csr_index,
   input logic [7:0] csr_wdata
);

   localparam int unsigned PtrW = (RspDepth > 1) ? $clog2(RspDepth) : 1;
   localparam int unsigned CntW = $clog2(RspDepth + 1);
   localparam logic [CntW-1:0] ReadyLimit = CntW'(RspDepth - 2);
   localparam logic [PtrW-1:0] PtrLast = PtrW'(RspDepth - 1);

   // Configuration registers.
   logic [7:0] header_one_ff, header_two_ff, rw_req_ff, rw_rsp_ff, rw_err_ff;

   // Parser state.
   pfp_pkg::phase_type phase_ff, phase_in;
   logic [3:0] byte_index_ff, byte_index_in;
   logic [15:0] id_ff, id_in;
   logic [23:0] src_ff, src_in;
   logic [23:0] dst_ff, dst_in;
   logic [7:0] service_ff, service_in;
   logic [7:0] props_left_ff, props_left_in;
   logic [7:0] bytes_left_ff, bytes_left_in;
   logic [7:0] code_ff, code_in;
   pfp_pkg::list_type list_ff, list_in;
   pfp_pkg::cause_type error_ff, error_in;

   // Result queue.
   pfp_pkg::rec_type rsp_q [RspDepth];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;

   pfp_pkg::rec_type rec_main, rec_end, head;
   logic main_v, end_v;
   logic req_fire, rsp_fire;
   logic [7:0] b;
   logic [7:0] bytes_dec, props_dec;
   logic rw_code;

   function automatic logic [PtrW-1:0] ptr_next(input logic [PtrW-1:0] p);
      return (p == PtrLast) ? '0 : p + 1'b1;
   endfunction

   // Phase after a list count is known: a list with properties opens with a
   // code byte; an empty set list goes on to the get count and any other empty list to the trailer.
   function automatic pfp_pkg::phase_type list_entry(input logic [7:0] props,
                                                     input pfp_pkg::list_type lst);
      if (props != '0) begin
         return pfp_pkg::PH_CODE;
      end
      return (lst == pfp_pkg::LIST_SET) ? pfp_pkg::PH_GETCOUNT : pfp_pkg::PH_TRAIL;
   endfunction

   assign req_tready = (count_ff <= ReadyLimit);
   assign req_fire = req_tvalid && req_tready;
   assign rsp_tvalid = (count_ff != '0);
   assign rsp_fire = rsp_tvalid && rsp_tready;
   assign b = req_tdata;
   assign bytes_dec = bytes_left_ff - 8'd1;
   assign props_dec = props_left_ff - 8'd1;
   assign rw_code = (service_ff == rw_req_ff) || (service_ff == rw_rsp_ff) ||
                    (service_ff == rw_err_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         header_one_ff <= pfp_pkg::HEADER_ONE_RST;
         header_two_ff <= pfp_pkg::HEADER_TWO_RST;
         rw_req_ff <= pfp_pkg::RW_REQ_RST;
         rw_rsp_ff <= pfp_pkg::RW_RSP_RST;
         rw_err_ff <= pfp_pkg::RW_ERR_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            pfp_pkg::REG_HEADER_ONE: header_one_ff <= csr_wdata;
            pfp_pkg::REG_HEADER_TWO: header_two_ff <= csr_wdata;
            pfp_pkg::REG_RW_REQ: rw_req_ff <= csr_wdata;
            pfp_pkg::REG_RW_RSP: rw_rsp_ff <= csr_wdata;
            pfp_pkg::REG_RW_ERR: rw_err_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // One byte of parsing: next state and up to two result records.
   always_comb begin
      phase_in = phase_ff;
      byte_index_in = byte_index_ff;
      id_in = id_ff;
      src_in = src_ff;
      dst_in = dst_ff;
      service_in = service_ff;
      props_left_in = props_left_ff;
      bytes_left_in = bytes_left_ff;
      code_in = code_ff;
      list_in = list_ff;
      error_in = error_ff;
      rec_main = '0;
      rec_end = '0;
      main_v = 1'b0;
      end_v = 1'b0;

      if (req_fire) begin
         unique case (phase_ff)
            pfp_pkg::PH_HEADER: begin
               priority if (byte_index_ff == 4'd0) begin
                  if (b != header_one_ff) error_in = pfp_pkg::CAUSE_HDR_ONE;
               end else if (byte_index_ff == 4'd1) begin
                  if (b != header_two_ff && error_ff == pfp_pkg::CAUSE_NONE) begin
                     error_in = pfp_pkg::CAUSE_HDR_TWO;
                  end
               end else if (byte_index_ff <= pfp_pkg::HDR_ID_LAST) begin
                  id_in = {id_ff[7:0], b};
               end else if (byte_index_ff <= pfp_pkg::HDR_SRC_LAST) begin
                  src_in = {src_ff[15:0], b};
               end else if (byte_index_ff <= pfp_pkg::HDR_DST_LAST) begin
                  dst_in = {dst_ff[15:0], b};
               end else if (byte_index_ff == pfp_pkg::HDR_SVC_IDX) begin
                  service_in = b;
               end else begin
                  if (error_ff != pfp_pkg::CAUSE_NONE) begin
                     phase_in = pfp_pkg::PH_SKIP;
                  end else begin
                     list_in = rw_code ? pfp_pkg::LIST_SET : pfp_pkg::LIST_SINGLE;
                     main_v = 1'b1;
                     rec_main.kind = pfp_pkg::KIND_HEADER;
                     rec_main.trans_id = id_ff;
                     rec_main.src_object = src_ff;
                     rec_main.dst_object = dst_ff;
                     rec_main.service_code = service_ff;
                     rec_main.list_id = list_in;
                     props_left_in = b;
                     phase_in = list_entry(b, list_in);
                  end
               end
               if (byte_index_ff < pfp_pkg::HDR_LAST_IDX) begin
                  byte_index_in = byte_index_ff + 4'd1;
               end
            end
            pfp_pkg::PH_CODE: begin
               code_in = b;
               phase_in = pfp_pkg::PH_LEN;
            end
            pfp_pkg::PH_LEN: begin
               bytes_left_in = b;
               main_v = 1'b1;
               rec_main.kind = pfp_pkg::KIND_PROP;
               rec_main.list_id = list_ff;
               rec_main.property_code = code_ff;
               rec_main.data_count = b;
               if (b == '0) begin
                  props_left_in = props_dec;
                  phase_in = list_entry(props_dec, list_ff);
               end else begin
                  phase_in = pfp_pkg::PH_DATA;
               end
            end
            pfp_pkg::PH_DATA: begin
               main_v = 1'b1;
               rec_main.kind = pfp_pkg::KIND_DATA;
               rec_main.list_id = list_ff;
               rec_main.property_code = code_ff;
               rec_main.payload_byte = b;
               bytes_left_in = bytes_dec;
               if (bytes_dec == '0) begin
                  props_left_in = props_dec;
                  phase_in = list_entry(props_dec, list_ff);
               end
            end
            pfp_pkg::PH_GETCOUNT: begin
               list_in = pfp_pkg::LIST_GET;
               props_left_in = b;
               phase_in = list_entry(b, pfp_pkg::LIST_GET);
            end
            default: ;
         endcase

         if (req_tlast) begin
            end_v = 1'b1;
            rec_end.last_of_item = 1'b1;
            if (phase_in == pfp_pkg::PH_TRAIL) begin
               rec_end.kind = pfp_pkg::KIND_DONE;
            end else begin
               rec_end.kind = pfp_pkg::KIND_ERROR;
               rec_end.error_cause = (phase_in == pfp_pkg::PH_SKIP) ?
                                     error_in : pfp_pkg::CAUSE_SHORT;
            end
            phase_in = pfp_pkg::PH_HEADER;
            byte_index_in = '0;
            id_in = '0;
            src_in = '0;
            dst_in = '0;
            service_in = '0;
            props_left_in = '0;
            bytes_left_in = '0;
            code_in = '0;
            list_in = pfp_pkg::LIST_SINGLE;
            error_in = pfp_pkg::CAUSE_NONE;
         end else begin
            rec_main.last_of_item = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= pfp_pkg::PH_HEADER;
         byte_index_ff <= '0;
         id_ff <= '0;
         src_ff <= '0;
         dst_ff <= '0;
         service_ff <= '0;
         props_left_ff <= '0;
         bytes_left_ff <= '0;
         code_ff <= '0;
         list_ff <= pfp_pkg::LIST_SINGLE;
         error_ff <= pfp_pkg::CAUSE_NONE;
      end else begin
         phase_ff <= phase_in;
         byte_index_ff <= byte_index_in;
         id_ff <= id_in;
         src_ff <= src_in;
         dst_ff <= dst_in;
         service_ff <= service_in;
         props_left_ff <= props_left_in;
         bytes_left_ff <= bytes_left_in;
         code_ff <= code_in;
         list_ff <= list_in;
         error_ff <= error_in;
      end
   end

   // Queue bookkeeping: up to two pushes and one pop a cycle.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      if (main_v && end_v) begin
         wr_ptr_in = ptr_next(ptr_next(wr_ptr_ff));
      end else if (main_v || end_v) begin
         wr_ptr_in = ptr_next(wr_ptr_ff);
      end
      rd_ptr_in = rsp_fire ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
      count_in = count_ff + CntW'(main_v) + CntW'(end_v) - CntW'(rsp_fire);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (main_v) begin
         rsp_q[wr_ptr_ff] <= rec_main;
      end
      if (end_v) begin
         rsp_q[main_v ? ptr_next(wr_ptr_ff) : wr_ptr_ff] <= rec_end;
      end
   end

   assign head = rsp_q[rd_ptr_ff];
   assign rsp_tuser = head.kind;
   assign rsp_tlast = head.last_of_item;
   assign rsp_tdata = {4'b0000, head.error_cause, head.payload_byte, head.data_count,
                       head.property_code, head.list_id, head.service_code,
                       head.dst_object, head.src_object, head.trans_id};

   `ASSERT_ALWAYS(a_queue_bound, count_ff <= CntW'(RspDepth), "result queue overflow")
   `ASSERT_ALWAYS(a_index_bound, byte_index_ff <= pfp_pkg::HDR_LAST_IDX,
                  "header byte index out of range")
   `ASSERT_ALWAYS(a_error_only_hdr,
                  error_ff == pfp_pkg::CAUSE_NONE || phase_ff == pfp_pkg::PH_HEADER ||
                  phase_ff == pfp_pkg::PH_SKIP, "header error kept past the header")
   `ASSERT_NEXT(a_frame_restart, req_fire && req_tlast,
                phase_ff == pfp_pkg::PH_HEADER && byte_index_ff == '0,
                "parser not back at header after frame end")
   `ASSERT_NEXT(a_end_queued, req_fire && req_tlast, count_ff != '0,
                "frame end left no result in the queue")

endmodule
